/* src/drc_pkg.sv */
// shared types and constants for the dirty rectangle coalescer
// no dependencies
`default_nettype none

package drc_pkg;

    localparam int COORD_W   = 16;
    localparam int DRAIN_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd640;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd480;

    // x sits in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_box;

    typedef struct packed {
        logic overlap;
        t_box uni;
        t_box clamp;
        logic clamp_valid;
    } t_alu_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MCMP,
        S_FRD,
        S_FOUT
    } t_state;

endpackage

`default_nettype wire

/* src/drc_rect_mem.sv */
// rectangle table storage, one write port and one registered read port
// depends on drc_pkg
`default_nettype none

module drc_rect_mem
    import drc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_box          i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_box               o_rdata
);

    t_box r_mem [DEPTH];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/drc_rect_alu.sv */
// shared rectangle unit: overlap test, bounding-box union and screen clamp
// depends on drc_pkg
`default_nettype none

module drc_rect_alu
    import drc_pkg::*;
(
    input  wire t_box               i_a,
    input  wire t_box               i_b,
    input  wire logic               i_clamp,
    input  wire logic [COORD_W-1:0] i_screen_w,
    input  wire logic [COORD_W-1:0] i_screen_h,
    output t_alu_res                o_res
);

    logic [COORD_W-1:0] cx, cy;
    logic [COORD_W-1:0] base_x, base_y;
    logic [COORD_W-1:0] aex, aey, bex, bey;
    logic [COORD_W-1:0] ex, ey, cex, cey;
    t_box               uni, clamp;

    always_comb begin
        cx = (i_a.x > i_screen_w) ? i_screen_w : i_a.x;
        cy = (i_a.y > i_screen_h) ? i_screen_h : i_a.y;
        // end adders shared between merge and clamp
        base_x = i_clamp ? cx : i_a.x;
        base_y = i_clamp ? cy : i_a.y;
        aex = base_x + i_a.w;
        aey = base_y + i_a.h;
        bex = i_b.x + i_b.w;
        bey = i_b.y + i_b.h;

        ex = (aex > bex) ? aex : bex;
        ey = (aey > bey) ? aey : bey;
        uni.x = (i_a.x < i_b.x) ? i_a.x : i_b.x;
        uni.y = (i_a.y < i_b.y) ? i_a.y : i_b.y;
        uni.w = ex - uni.x;
        uni.h = ey - uni.y;

        cex = (aex > i_screen_w) ? i_screen_w : aex;
        cey = (aey > i_screen_h) ? i_screen_h : aey;
        clamp.x = cx;
        clamp.y = cy;
        clamp.w = cex - cx;
        clamp.h = cey - cy;

        o_res.overlap     = !(aex <= i_b.x || bex <= i_a.x || aey <= i_b.y || bey <= i_a.y);
        o_res.uni         = uni;
        o_res.clamp       = clamp;
        o_res.clamp_valid = (clamp.w != '0) && (clamp.h != '0);
    end

endmodule

`default_nettype wire

/* src/dirty_rect_coalescer_core.sv */
// dirty rectangle coalescer top level: sequencer, config registers, output register
// depends on drc_pkg, drc_rect_mem, drc_rect_alu
`default_nettype none

// Collects dirty screen rectangles in a table of TABLE_DEPTH entries. A mark beat
// (tuser 0) with nonzero width and height is merged into the first stored rectangle
// it overlaps, else appended, else merged into entry 0 when the table is full; a
// zero-sized mark is dropped. A flush beat (tuser 1) sends every stored
// rectangle clamped to the screen, last one marked with tlast, then empties the
// table; an empty table gives one invalid beat with tlast. The table sits in a
// memory with one read port feeding one shared compare/merge/clamp unit; each
// entry is read and then compared or clamped in turn, and a flush also waits on
// any output stall. The input is not ready while an item is worked on. A result
// waits in an output register while the next item is taken.
module dirty_rect_coalescer_core
    import drc_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,  // rect_x, rect_y, rect_w, rect_h
    input  wire logic                 s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // region_x, region_y, region_w, region_h, drained_count, zero pad
    output logic [71:0]               m_axis_tdata,
    output logic                      m_axis_tuser,  // region_valid
    output logic                      m_axis_tlast,  // last_region
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    t_box               r_nb, n_nb;
    t_box               r_e0, n_e0;
    logic [COORD_W-1:0] r_screen_w, r_screen_h;

    t_box               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               r_out_region, n_out_region;
    logic               r_out_last, n_out_last;
    logic [DRAIN_W-1:0] r_out_drained, n_out_drained;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    t_box               mem_wdata, mem_rdata;
    t_alu_res           alu;
    logic               in_fire, out_free, at_end, is_last;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign at_end   = (r_idx == r_count);
    assign is_last  = ((r_idx + CW'(1)) == r_count);

    drc_rect_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    drc_rect_alu u_alu (
        .i_a        (mem_rdata),
        .i_b        (r_nb),
        .i_clamp    (r_state == S_FOUT),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .o_res      (alu)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser) begin
                        n_state = S_FRD;
                    end else if (s_axis_tdata[47:32] != '0 && s_axis_tdata[63:48] != '0) begin
                        n_state = S_MRD;
                    end
                end
            end
            S_MRD: begin
                n_state = at_end ? S_IDLE : S_MCMP;
            end
            S_MCMP: begin
                n_state = alu.overlap ? S_IDLE : S_MRD;
            end
            S_FRD: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_FOUT;
                end
            end
            S_FOUT: begin
                if (out_free) begin
                    n_state = is_last ? S_IDLE : S_FRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_count       = r_count;
        n_idx         = r_idx;
        n_nb          = r_nb;
        n_e0          = r_e0;
        n_out         = r_out;
        n_out_region  = r_out_region;
        n_out_last    = r_out_last;
        n_out_drained = r_out_drained;
        n_out_valid   = r_out_valid && !m_axis_tready;
        mem_we        = 1'b0;
        mem_waddr     = r_idx[AW-1:0];
        mem_wdata     = r_nb;
        mem_re        = 1'b0;
        mem_raddr     = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_nb  = s_axis_tdata;
                    n_idx = '0;
                end
            end
            S_MRD: begin
                if (at_end) begin
                    mem_we = 1'b1;
                    if (r_count < CW'(TABLE_DEPTH)) begin
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = r_nb;
                        n_count   = r_count + CW'(1);
                    end else begin
                        mem_waddr = '0;
                        mem_wdata = r_e0;
                    end
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_MCMP: begin
                if (alu.overlap) begin
                    mem_we    = 1'b1;
                    mem_wdata = alu.uni;
                end else begin
                    if (r_idx == '0) begin
                        n_e0 = alu.uni;
                    end
                    n_idx = r_idx + CW'(1);
                end
            end
            S_FRD: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_out_valid   = 1'b1;
                        n_out         = '0;
                        n_out_region  = 1'b0;
                        n_out_last    = 1'b1;
                        n_out_drained = '0;
                    end
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_FOUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out         = alu.clamp;
                    n_out_region  = alu.clamp_valid;
                    n_out_last    = is_last;
                    n_out_drained = DRAIN_W'(r_count);
                    n_idx         = r_idx + CW'(1);
                    if (is_last) begin
                        n_count = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb          <= n_nb;
        r_e0          <= n_e0;
        r_out         <= n_out;
        r_out_region  <= n_out_region;
        r_out_last    <= n_out_last;
        r_out_drained <= n_out_drained;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_WIDTH_RST;
            r_screen_h <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_drained, r_out};
    assign m_axis_tuser  = r_out_region;
    assign m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRD || r_state == S_MCMP || r_state == S_FOUT) |-> r_idx <= r_count)
        else $error("table index past entry count");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOUT && out_free && is_last) |=> (r_count == '0 && m_axis_tlast))
        else $error("final flush beat did not empty the table");

endmodule

`default_nettype wire
